// ----- sv/ctst_pkg.sv -----
package ctst_pkg;

    localparam int OFFSET_WIDTH    = 32;
    localparam int POS_WIDTH       = 16;
    localparam int KIND_WIDTH      = 5;
    localparam int CH_WIDTH        = 8;
    localparam int IN_TDATA_WIDTH  = ((CH_WIDTH + 7) / 8) * 8;
    localparam int OUT_BITS        = OFFSET_WIDTH + 5 * POS_WIDTH;
    localparam int OUT_TDATA_WIDTH = ((OUT_BITS + 7) / 8) * 8;
    localparam int WIDE_WIDTH      = OFFSET_WIDTH + POS_WIDTH;

    typedef logic [OFFSET_WIDTH-1:0] t_ofs;
    typedef logic [POS_WIDTH-1:0]    t_pos;
    typedef logic [KIND_WIDTH-1:0]   t_kind;
    typedef logic [CH_WIDTH-1:0]     t_ch;
    typedef logic [1:0]              t_cnt;
    typedef logic [WIDE_WIDTH-1:0]   t_wide;

    localparam t_pos POS_MAX = '1;
    localparam t_pos POS_ONE = t_pos'(1);

    localparam t_kind KIND_WORD   = t_kind'(0);
    localparam t_kind KIND_INT    = t_kind'(1);
    localparam t_kind KIND_DEC    = t_kind'(2);
    localparam t_kind KIND_NL     = t_kind'(3);
    localparam t_kind KIND_LPAREN = t_kind'(4);
    localparam t_kind KIND_RPAREN = t_kind'(5);
    localparam t_kind KIND_LBRACK = t_kind'(6);
    localparam t_kind KIND_RBRACK = t_kind'(7);
    localparam t_kind KIND_DOT    = t_kind'(8);
    localparam t_kind KIND_PLUS   = t_kind'(9);
    localparam t_kind KIND_MINUS  = t_kind'(10);
    localparam t_kind KIND_SLASH  = t_kind'(11);
    localparam t_kind KIND_STAR   = t_kind'(12);
    localparam t_kind KIND_COMMA  = t_kind'(13);
    localparam t_kind KIND_BAR    = t_kind'(14);
    localparam t_kind KIND_SEMI   = t_kind'(15);
    localparam t_kind KIND_END    = t_kind'(16);
    localparam t_kind KIND_ERR    = t_kind'(17);

    localparam t_ch CH_NL     = 8'h0A;
    localparam t_ch CH_UNDER  = 8'h5F;
    localparam t_ch CH_QUEST  = 8'h3F;
    localparam t_ch CH_BANG   = 8'h21;
    localparam t_ch CH_TICK   = 8'h27;
    localparam t_ch CH_DOT    = 8'h2E;
    localparam t_ch CH_LPAREN = 8'h28;
    localparam t_ch CH_RPAREN = 8'h29;
    localparam t_ch CH_LBRACK = 8'h5B;
    localparam t_ch CH_RBRACK = 8'h5D;
    localparam t_ch CH_PLUS   = 8'h2B;
    localparam t_ch CH_MINUS  = 8'h2D;
    localparam t_ch CH_SLASH  = 8'h2F;
    localparam t_ch CH_STAR   = 8'h2A;
    localparam t_ch CH_COMMA  = 8'h2C;
    localparam t_ch CH_BAR    = 8'h7C;
    localparam t_ch CH_SEMI   = 8'h3B;
    localparam t_ch CH_SPACE  = 8'h20;
    localparam t_ch CH_TAB    = 8'h09;
    localparam t_ch CH_CR     = 8'h0D;

    typedef enum logic [4:0] {
        MODE_BASE = 5'b00001,
        MODE_WORD = 5'b00010,
        MODE_INT  = 5'b00100,
        MODE_DEC  = 5'b01000,
        MODE_ERR  = 5'b10000
    } t_mode;

    typedef struct packed {
        t_kind kind;
        t_ofs  ofs;
        t_pos  len;
        t_pos  start_line;
        t_pos  start_col;
        t_pos  end_line;
        t_pos  end_col;
        logic  last;
    } t_token;

    function automatic t_pos sat_inc(input t_pos v);
        return (v == POS_MAX) ? POS_MAX : v + POS_ONE;
    endfunction

    function automatic t_pos len_sat(input t_ofs diff);
        t_wide wide;
        wide = t_wide'(diff);
        return (wide > t_wide'(POS_MAX)) ? POS_MAX : t_pos'(wide);
    endfunction

    function automatic logic is_alpha(input t_ch c);
        return c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
    endfunction

    function automatic logic is_digit(input t_ch c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_blank(input t_ch c);
        return c inside {CH_SPACE, [CH_TAB:CH_CR]};
    endfunction

    function automatic t_kind sym_kind(input t_ch c);
        t_kind k;
        case (c)
            CH_LPAREN: k = KIND_LPAREN;
            CH_RPAREN: k = KIND_RPAREN;
            CH_LBRACK: k = KIND_LBRACK;
            CH_RBRACK: k = KIND_RBRACK;
            CH_DOT:    k = KIND_DOT;
            CH_PLUS:   k = KIND_PLUS;
            CH_MINUS:  k = KIND_MINUS;
            CH_SLASH:  k = KIND_SLASH;
            CH_STAR:   k = KIND_STAR;
            CH_COMMA:  k = KIND_COMMA;
            CH_BAR:    k = KIND_BAR;
            CH_SEMI:   k = KIND_SEMI;
            default:   k = KIND_ERR;
        endcase
        return k;
    endfunction

endpackage

// ----- sv/ctst_lexer.sv -----
module ctst_lexer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  ctst_pkg::t_ch    i_ch,
    input  logic             i_eod,
    input  ctst_pkg::t_cnt   i_free,
    output logic             o_fire,
    output ctst_pkg::t_cnt   o_cnt,
    output ctst_pkg::t_token o_tok0,
    output ctst_pkg::t_token o_tok1
);
    import ctst_pkg::*;

    t_mode r_mode, n_mode;
    t_ofs  r_tok_ofs, n_tok_ofs;
    t_ofs  r_next_ofs, n_next_ofs;
    t_pos  r_tok_line, n_tok_line;
    t_pos  r_tok_col, n_tok_col;
    t_pos  r_line, n_line;
    t_pos  r_col, n_col;

    t_token flush_tok;
    t_token tok_b;
    logic   pending;
    logic   has_a;
    logic   has_b;
    logic   adv;
    logic   cont;
    t_kind  sk;

    always_comb begin
        n_mode     = r_mode;
        n_tok_ofs  = r_tok_ofs;
        n_next_ofs = r_next_ofs;
        n_tok_line = r_tok_line;
        n_tok_col  = r_tok_col;
        n_line     = r_line;
        n_col      = r_col;

        pending = (r_mode == MODE_WORD) || (r_mode == MODE_INT) || (r_mode == MODE_DEC);
        flush_tok.kind       = (r_mode == MODE_WORD) ? KIND_WORD :
                               (r_mode == MODE_INT)  ? KIND_INT  : KIND_DEC;
        flush_tok.ofs        = r_tok_ofs;
        flush_tok.len        = len_sat(r_next_ofs - r_tok_ofs);
        flush_tok.start_line = r_tok_line;
        flush_tok.start_col  = r_tok_col;
        flush_tok.end_line   = r_line;
        flush_tok.end_col    = r_col;
        flush_tok.last       = 1'b0;

        sk = sym_kind(i_ch);
        tok_b.kind       = sk;
        tok_b.ofs        = r_next_ofs;
        tok_b.len        = POS_ONE;
        tok_b.start_line = r_line;
        tok_b.start_col  = r_col;
        tok_b.end_line   = r_line;
        tok_b.end_col    = sat_inc(r_col);
        tok_b.last       = 1'b1;

        has_a = 1'b0;
        has_b = 1'b0;
        adv   = 1'b0;
        cont  = 1'b0;

        if (i_eod) begin
            has_a          = pending;
            has_b          = 1'b1;
            tok_b.kind     = KIND_END;
            tok_b.len      = '0;
            tok_b.end_col  = r_col;
            n_mode         = MODE_BASE;
            n_tok_ofs      = '0;
            n_next_ofs     = '0;
            n_tok_line     = POS_ONE;
            n_tok_col      = POS_ONE;
            n_line         = POS_ONE;
            n_col          = POS_ONE;
        end else if (r_mode != MODE_ERR) begin
            if (r_mode == MODE_WORD) begin
                cont = is_alpha(i_ch) || is_digit(i_ch) || (i_ch == CH_UNDER) ||
                       (i_ch == CH_QUEST) || (i_ch == CH_BANG);
            end else if ((r_mode == MODE_INT) || (r_mode == MODE_DEC)) begin
                cont = is_alpha(i_ch) || is_digit(i_ch) || (i_ch == CH_TICK) ||
                       ((i_ch == CH_DOT) && (r_mode == MODE_INT));
            end
            adv = 1'b1;
            if (cont) begin
                if ((i_ch == CH_DOT) && (r_mode == MODE_INT)) begin
                    n_mode = MODE_DEC;
                end
            end else begin
                has_a  = pending;
                n_mode = MODE_BASE;
                if (is_alpha(i_ch) || is_digit(i_ch)) begin
                    n_mode     = is_alpha(i_ch) ? MODE_WORD : MODE_INT;
                    n_tok_ofs  = r_next_ofs;
                    n_tok_line = r_line;
                    n_tok_col  = r_col;
                end else if (i_ch == CH_NL) begin
                    has_b          = 1'b1;
                    tok_b.kind     = KIND_NL;
                    tok_b.end_line = sat_inc(r_line);
                    tok_b.end_col  = POS_ONE;
                end else if (!is_blank(i_ch)) begin
                    has_b = 1'b1;
                    if (sk == KIND_ERR) begin
                        n_mode = MODE_ERR;
                    end
                end
            end
        end

        if (adv) begin
            n_next_ofs = r_next_ofs + t_ofs'(1);
            if (i_ch == CH_NL) begin
                n_line = sat_inc(r_line);
                n_col  = POS_ONE;
            end else begin
                n_col = sat_inc(r_col);
            end
        end
    end

    assign o_cnt  = t_cnt'(has_a) + t_cnt'(has_b);
    assign o_fire = i_valid && (o_cnt <= i_free);

    always_comb begin
        o_tok0      = has_a ? flush_tok : tok_b;
        o_tok0.last = (o_cnt == t_cnt'(1));
        o_tok1      = tok_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_BASE;
            r_tok_ofs  <= '0;
            r_next_ofs <= '0;
            r_tok_line <= POS_ONE;
            r_tok_col  <= POS_ONE;
            r_line     <= POS_ONE;
            r_col      <= POS_ONE;
        end else if (o_fire) begin
            r_mode     <= n_mode;
            r_tok_ofs  <= n_tok_ofs;
            r_next_ofs <= n_next_ofs;
            r_tok_line <= n_tok_line;
            r_tok_col  <= n_tok_col;
            r_line     <= n_line;
            r_col      <= n_col;
        end
    end

endmodule

// ----- sv/ctst_outq.sv -----
module ctst_outq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ctst_pkg::t_cnt   i_push_cnt,
    input  ctst_pkg::t_token i_tok0,
    input  ctst_pkg::t_token i_tok1,
    output ctst_pkg::t_cnt   o_free,
    output logic             o_valid,
    input  logic             i_ready,
    output ctst_pkg::t_token o_head
);
    import ctst_pkg::*;

    t_cnt   r_cnt, n_cnt;
    t_token r_q [2];
    t_token n_q [2];
    logic   pop;
    t_cnt   keep;

    assign o_valid = (r_cnt != '0);
    assign o_head  = r_q[0];
    assign pop     = o_valid && i_ready;
    assign keep    = r_cnt - t_cnt'(pop);
    assign o_free  = t_cnt'(2) - keep;
    assign n_cnt   = keep + i_push_cnt;

    always_comb begin
        n_q[0] = pop ? r_q[1] : r_q[0];
        n_q[1] = r_q[1];
        if (i_push_cnt != '0) begin
            n_q[keep[0]] = i_tok0;
        end
        if (i_push_cnt == t_cnt'(2)) begin
            n_q[1] = i_tok1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q[0] <= n_q[0];
        r_q[1] <= n_q[1];
    end

endmodule

// ----- sv/character_stream_tokenizer.sv -----
// Byte-stream tokenizer.
// Slave side: one document byte per word in s_axis_tdata; s_axis_tlast marks
// the end of the document (the byte is then ignored).
// Master side: one token per word; m_axis_tuser carries the token kind,
// m_axis_tlast marks the final token caused by one input word.
// Each accepted byte lands in an input register; once the output queue has
// room, the lexer classifies it against the current mode and writes zero,
// one or two tokens into a two-entry output queue, whose head is presented
// on the master side. The end marker flushes the pending token and adds an
// end token.
// Throughput is one byte per cycle while tokens are taken. A byte that ends a
// pending word or number and is itself a token yields two tokens, and the
// single output port drains them one at a time, so the slave side may pause.
// When the receiver stalls, the queue fills and s_axis_tready drops; nothing
// is lost. Reset empties the queue and input register and restarts position
// at offset 0, line 1, column 1.
module character_stream_tokenizer (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [ctst_pkg::IN_TDATA_WIDTH-1:0]    s_axis_tdata,  // ch
    input  logic                                   s_axis_tlast,  // end_of_doc
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // start_offset, text_length, start_line, start_col, end_line, end_col
    output logic [ctst_pkg::OUT_TDATA_WIDTH-1:0]   m_axis_tdata,
    output logic [ctst_pkg::KIND_WIDTH-1:0]        m_axis_tuser,  // token_kind
    output logic                                   m_axis_tlast   // last_of_run
);
    import ctst_pkg::*;

    logic   r_in_valid;
    t_ch    r_ch;
    logic   r_eod;
    logic   fire;
    t_cnt   res_cnt;
    t_cnt   q_free;
    t_token tok0;
    t_token tok1;
    t_token head;
    logic   s_accept;

    assign s_axis_tready = !r_in_valid || fire;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_ch  <= s_axis_tdata[CH_WIDTH-1:0];
            r_eod <= s_axis_tlast;
        end
    end

    ctst_lexer u_lexer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .i_ch    (r_ch),
        .i_eod   (r_eod),
        .i_free  (q_free),
        .o_fire  (fire),
        .o_cnt   (res_cnt),
        .o_tok0  (tok0),
        .o_tok1  (tok1)
    );

    ctst_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (fire ? res_cnt : t_cnt'(0)),
        .i_tok0     (tok0),
        .i_tok1     (tok1),
        .o_free     (q_free),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_head     (head)
    );

    assign m_axis_tdata = OUT_TDATA_WIDTH'({head.end_col, head.end_line, head.start_col,
                                            head.start_line, head.len, head.ofs});
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.last;

    a_end_closes_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_END)) |-> (m_axis_tlast && (head.len == '0)))
        else $error("end token not last of run or nonzero length");

    a_nl_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_NL)) |->
        ((head.len == POS_ONE) && (head.end_col == POS_ONE)))
        else $error("newline token malformed");

    a_eod_yields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_eod) |-> ((res_cnt != '0) && tok1.last))
        else $error("end marker produced no end token");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule
